// File: hw/rtl/bwva_pkg.sv
`timescale 1ns / 1ps
package bwva_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_REPEAT = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;
    localparam logic [1:0] REG_ROWS   = 2'd3;

    // Combining modes. The spare code acts as latest block only.
    localparam logic [1:0] MODE_LATEST   = 2'd0;
    localparam logic [1:0] MODE_RUNNING  = 2'd1;
    localparam logic [1:0] MODE_WINDOW   = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam int TOTAL_W = 48;
    localparam int DIV_W   = 48;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [31:0]       divisor;
    } t_div_req;

    // Answer of the shared divider: quotient saturated to signed 32 bits.
    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

// File: hw/rtl/block_and_window_vector_average.sv
`timescale 1ns / 1ps
// Steps: a non-final item is accepted and read, then modified, then written back;
// a row outside the row count is taken and dropped.
// A final-repeat item runs two divisions in turn on one shared divider before its
// result is shown. One item is in work at a time.
// A result waits in an output register; the next item is taken once it clears.
// Reset: synchronous, active low. The row totals are cleared by a pass over all
// MAX_ROWS rows after reset, during which no item is accepted.
module block_and_window_vector_average #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_WINDOW = 16,
    parameter int MAX_REPEAT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [9:0]         i_row,
    input  logic signed [31:0] i_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [9:0]         o_out_row,
    output logic signed [31:0] o_average,
    output logic [31:0]        o_normalizer,
    output logic               o_last_row,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int RPW = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;
    localparam int SW  = 32 + RPW;
    localparam int TW  = bwva_pkg::TOTAL_W;
    localparam int DW  = bwva_pkg::DIV_W;
    localparam logic signed [TW-1:0] TMAX = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] TMIN = {1'b1, {(TW-1){1'b0}}};

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_DIV1  = 3'd4;
    localparam logic [2:0] ST_DIV2  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Memories.
    logic [SW-1:0] m_sum   [MAX_ROWS];
    logic [TW-1:0] m_total [MAX_ROWS];
    logic [31:0]   m_ring  [MAX_WINDOW*(2**RW)];

    logic [2:0]  r_state;
    logic [1:0]  r_mode;
    logic [8:0]  r_rep_cfg;
    logic [4:0]  r_win_cfg;
    logic [10:0] r_rows_cfg;
    logic [RW:0] r_clr;

    logic [15:0] r_rep_idx;
    logic [WW:0] r_wpos;
    logic        r_wfull;
    logic [31:0] r_norm_cnt;

    logic [RW-1:0]     r_row;
    logic signed [31:0] r_sample;
    logic              r_last;
    logic signed [SW-1:0] r_sum_rd;
    logic signed [TW-1:0] r_tot_rd;
    logic signed [31:0]   r_ring_rd;
    logic signed [SW-1:0] r_sum_new;
    logic [31:0]          r_norm;
    logic [WW-1:0]        r_slot_pos;

    logic        r_ovalid;
    logic [9:0]  r_orow;
    logic [31:0] r_oavg;
    logic [31:0] r_onorm;
    logic        r_olast;

    // Effective (clamped) configuration.
    logic [31:0] n_rows, n_reps, n_win;
    always_comb begin
        n_rows = (r_rows_cfg == '0) ? 32'd1 :
                 ({21'd0, r_rows_cfg} > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : {21'd0, r_rows_cfg};
        n_reps = (r_rep_cfg == '0) ? 32'd1 :
                 ({23'd0, r_rep_cfg} > 32'(MAX_REPEAT)) ? 32'(MAX_REPEAT) : {23'd0, r_rep_cfg};
        n_win  = (r_win_cfg == '0) ? 32'd1 :
                 ({27'd0, r_win_cfg} > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : {27'd0, r_win_cfg};
    end

    logic n_accept;
    assign o_ready  = (r_state == ST_IDLE) && !r_ovalid;
    assign n_accept = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // Row index at the width of the memories.
    logic [RW-1:0] n_in_row;
    assign n_in_row = RW'(i_row);

    logic n_final;
    assign n_final = ({16'd0, r_rep_idx} + 32'd1) >= n_reps;

    logic [WW:0] n_pos;
    assign n_pos = (r_wpos < (WW+1)'(MAX_WINDOW)) ? r_wpos : '0;

    // Divider.
    bwva_pkg::t_div_req n_req;
    bwva_pkg::t_div_rsp n_rsp;
    bwva_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(n_req), .o_rsp(n_rsp));

    // The block average is taken straight from the divider as it finishes.
    logic signed [31:0] n_avg;
    assign n_avg = n_rsp.quotient;

    // Total update after the block average is known.
    logic signed [TW+1:0] n_add, n_sub;
    logic signed [TW-1:0] n_tot_a, n_tot_new;
    always_comb begin
        n_add   = (TW+2)'(r_tot_rd) + (TW+2)'(n_avg);
        n_tot_a = (n_add > (TW+2)'(TMAX)) ? TMAX :
                  (n_add < (TW+2)'(TMIN)) ? TMIN : n_add[TW-1:0];
        n_sub   = (TW+2)'(n_tot_a) - (TW+2)'(r_ring_rd);
        if (r_mode == bwva_pkg::MODE_RUNNING) begin
            n_tot_new = n_tot_a;
        end else if (r_mode == bwva_pkg::MODE_WINDOW) begin
            if (r_wfull) begin
                n_tot_new = (n_sub > (TW+2)'(TMAX)) ? TMAX :
                            (n_sub < (TW+2)'(TMIN)) ? TMIN : n_sub[TW-1:0];
            end else begin
                n_tot_new = n_tot_a;
            end
        end else begin
            n_tot_new = TW'(n_avg);
        end
    end

    always_comb begin
        n_req.start    = 1'b0;
        n_req.dividend = DW'(r_sum_new);
        n_req.divisor  = n_reps;
        if (r_state == ST_MOD && n_final) begin
            n_req.start = 1'b1;
        end else if (r_state == ST_DIV1 && n_rsp.done) begin
            n_req.start    = 1'b1;
            n_req.dividend = DW'(n_tot_new);
            n_req.divisor  = r_norm;
        end
    end

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_sum_rd  <= m_sum[n_in_row];
            r_tot_rd  <= m_total[n_in_row];
            r_ring_rd <= m_ring[{n_pos[WW-1:0], n_in_row}];
        end
        if (r_state == ST_MOD) begin
            m_sum[r_row] <= r_sum_new;
        end
        if (r_state == ST_CLEAR) begin
            m_total[r_clr[RW-1:0]] <= '0;
        end else if (r_state == ST_DIV1 && n_rsp.done) begin
            m_total[r_row] <= n_tot_new;
            if (r_mode == bwva_pkg::MODE_WINDOW) begin
                m_ring[{r_slot_pos, r_row}] <= n_rsp.quotient;
            end
        end
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_mode     <= bwva_pkg::MODE_LATEST;
            r_rep_cfg  <= 9'd1;
            r_win_cfg  <= 5'd1;
            r_rows_cfg <= 11'd1024;
            r_rep_idx  <= '0;
            r_wpos     <= '0;
            r_wfull    <= 1'b0;
            r_norm_cnt <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bwva_pkg::REG_MODE:   r_mode     <= i_cfg_data[1:0];
                    bwva_pkg::REG_REPEAT: r_rep_cfg  <= i_cfg_data[8:0];
                    bwva_pkg::REG_WINDOW: r_win_cfg  <= i_cfg_data[4:0];
                    bwva_pkg::REG_ROWS:   r_rows_cfg <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (RW+1)'(MAX_ROWS - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (n_accept) begin
                        if ({22'd0, i_row} < n_rows) begin
                            r_row    <= n_in_row;
                            r_sample <= i_sample;
                            r_last   <= ({22'd0, i_row} == n_rows - 32'd1);
                            r_state  <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    r_sum_new <= (r_rep_idx == '0) ? SW'(r_sample) : r_sum_rd + SW'(r_sample);
                    r_state <= ST_MOD;
                end
                ST_MOD: begin
                    r_slot_pos <= n_pos[WW-1:0];
                    if (!n_final) begin
                        if (r_last) r_rep_idx <= r_rep_idx + 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        if (r_mode == bwva_pkg::MODE_RUNNING) begin
                            r_norm <= (r_norm_cnt == '1) ? '1 : r_norm_cnt + 1'b1;
                        end else if (r_mode == bwva_pkg::MODE_WINDOW) begin
                            r_norm <= (r_wfull || 32'(n_pos) + 32'd1 >= n_win)
                                      ? n_win : 32'(n_pos) + 32'd1;
                        end else begin
                            r_norm <= 32'd1;
                        end
                        r_state <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (n_rsp.done) begin
                        r_state <= ST_DIV2;
                        if (r_last) begin
                            r_norm_cnt <= r_norm;
                            r_rep_idx  <= '0;
                            if (r_mode == bwva_pkg::MODE_WINDOW) begin
                                if (32'(n_pos) + 32'd1 >= n_win) begin
                                    r_wpos  <= '0;
                                    r_wfull <= 1'b1;
                                end else begin
                                    r_wpos <= n_pos + 1'b1;
                                end
                            end
                        end
                    end
                end
                ST_DIV2: begin
                    if (n_rsp.done) begin
                        r_ovalid <= 1'b1;
                        r_orow   <= 10'(r_row);
                        r_oavg   <= n_rsp.quotient;
                        r_onorm  <= r_norm;
                        r_olast  <= r_last;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_out_row    = r_orow;
    assign o_average    = r_oavg;
    assign o_normalizer = r_onorm;
    assign o_last_row   = r_olast;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |-> r_state == ST_IDLE) else $error("item taken while busy");
    a_result_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ST_DIV2) else $error("stray result");
    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV2 |-> r_norm != '0) else $error("zero normalizer");
`endif

endmodule

// File: hw/rtl/bwva_divider.sv
`timescale 1ns / 1ps
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// The quotient is saturated to signed 32 bits.
module bwva_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bwva_pkg::t_div_req  i_req,
    output bwva_pkg::t_div_rsp  o_rsp
);

    localparam int W  = bwva_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [31:0]   r_den;
    logic          r_neg;
    logic          r_done;
    logic [31:0]   r_res;

    logic [W:0]    n_trial;
    logic [W-1:0]  n_rem_sh;
    logic [W-1:0]  n_mag;
    logic [W-1:0]  n_signed;

    // One shift and subtract step.
    always_comb begin
        n_rem_sh = {r_rem[W-2:0], r_quo[W-1]};
        n_trial  = {1'b0, n_rem_sh} - {{(W-31){1'b0}}, r_den};
        n_mag    = i_req.dividend[W-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;
        n_signed = r_neg ? (~r_quo + 1'b1) : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_quo  <= n_mag;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
                r_neg  <= i_req.dividend[W-1];
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    // Magnitude of at most 2^47, so the signed view is exact.
                    if (!r_neg && r_quo > W'(32'h7FFF_FFFF)) begin
                        r_res <= 32'h7FFF_FFFF;
                    end else if (r_neg && r_quo > W'(33'h8000_0000)) begin
                        r_res <= 32'h8000_0000;
                    end else begin
                        r_res <= n_signed[31:0];
                    end
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                    if (!n_trial[W]) begin
                        r_rem <= n_trial[W-1:0];
                        r_quo <= {r_quo[W-2:0], 1'b1};
                    end else begin
                        r_rem <= n_rem_sh;
                        r_quo <= {r_quo[W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_res;

endmodule

// File: tb/bwva_checker.sv
`timescale 1ns / 1ps
module bwva_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [9:0]  i_row,
    input  logic [31:0] i_sample,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [9:0]  i_out_row,
    input  logic [31:0] i_average,
    input  logic [31:0] i_normalizer,
    input  logic        i_last_row,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam longint TOTAL_HI = 64'sd140737488355327;
    localparam longint TOTAL_LO = -TOTAL_HI - 1;

    typedef struct packed {
        logic [9:0]  row;
        logic [31:0] average;
        logic [31:0] normalizer;
        logic        last;
    } t_row_avg;

    // Shadow of the registers and the averaging state.
    logic [1:0]  mode_reg;
    logic [8:0]  repeat_reg;
    logic [4:0]  window_reg;
    logic [10:0] rows_reg;
    longint      blk_sum [1024];
    longint      total [1024];
    longint      ring [16384];
    int unsigned rep_idx;
    int unsigned win_pos;
    bit          win_full;
    logic [31:0] norm_cnt;
    t_row_avg    avg_queue[$];

    function automatic longint clamp_reg(longint v, longint hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic longint sat_total(longint v);
        if (v > TOTAL_HI) return TOTAL_HI;
        if (v < TOTAL_LO) return TOTAL_LO;
        return v;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Fold one accepted sample into the state and queue its result, if any.
    task automatic average_sample(logic [9:0] row, logic [31:0] raw);
        longint   rows;
        longint   reps;
        longint   win;
        longint   s;
        longint   avg;
        longint   q;
        longint   pos;
        int       slot;
        bit       last;
        logic [31:0] norm;
        t_row_avg res;
        rows = clamp_reg(rows_reg, 1024);
        reps = clamp_reg(repeat_reg, 256);
        win  = clamp_reg(window_reg, 16);
        s = longint'(signed'(raw));
        if (row >= rows) return;
        last = (row == rows - 1);
        if (rep_idx == 0) blk_sum[row] = s;
        else blk_sum[row] = blk_sum[row] + s;
        if (longint'(rep_idx) + 1 < reps) begin
            if (last) rep_idx++;
            return;
        end
        avg = sat_word(blk_sum[row] / reps);
        if (mode_reg == bwva_pkg::MODE_RUNNING) begin
            total[row] = sat_total(total[row] + avg);
            norm = (norm_cnt == 32'hFFFF_FFFF) ? norm_cnt : norm_cnt + 1;
        end else if (mode_reg == bwva_pkg::MODE_WINDOW) begin
            pos = (win_pos < 16) ? win_pos : 0;
            slot = int'(pos * 1024 + row);
            total[row] = sat_total(total[row] + avg);
            if (win_full) total[row] = sat_total(total[row] - ring[slot]);
            ring[slot] = avg;
            if (win_full || pos + 1 >= win) norm = 32'(win);
            else norm = 32'(pos + 1);
            if (last) begin
                pos++;
                if (pos >= win) begin
                    pos = 0;
                    win_full = 1'b1;
                end
                win_pos = int'(pos);
            end
        end else begin
            total[row] = avg;
            norm = 32'd1;
        end
        if (last) begin
            norm_cnt = norm;
            rep_idx = 0;
        end
        q = sat_word(total[row] / longint'({32'd0, norm}));
        res.row = row;
        res.average = q[31:0];
        res.normalizer = norm;
        res.last = last;
        avg_queue.push_back(res);
    endtask

    // Watch the three channels at each edge.
    always @(posedge i_clk) begin
        t_row_avg want;
        if (!i_rst_n) begin
            repeat_reg = 9'd1;
            window_reg = 5'd1;
            rows_reg = 11'd1024;
            mode_reg = bwva_pkg::MODE_LATEST;
            for (int k = 0; k < 1024; k++) total[k] = 0;
            rep_idx = 0;
            win_pos = 0;
            win_full = 1'b0;
            norm_cnt = 32'd0;
            o_errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (avg_queue.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result row %0d avg %h", i_out_row, i_average);
                end else begin
                    want = avg_queue.pop_front();
                    if (want.row !== i_out_row || want.average !== i_average ||
                        want.normalizer !== i_normalizer || want.last !== i_last_row) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"mismatch: exp row %0d avg %h norm %0d last %b,",
                                      " got row %0d avg %h norm %0d last %b"},
                                     want.row, want.average, want.normalizer, want.last,
                                     i_out_row, i_average, i_normalizer, i_last_row);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bwva_pkg::REG_MODE:   mode_reg = i_cfg_data[1:0];
                    bwva_pkg::REG_REPEAT: repeat_reg = i_cfg_data[8:0];
                    bwva_pkg::REG_WINDOW: window_reg = i_cfg_data[4:0];
                    bwva_pkg::REG_ROWS:   rows_reg = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in) average_sample(i_row, i_sample);
        end
        o_pending = avg_queue.size();
    end

endmodule

// File: tb/block_and_window_vector_average_test.sv
`timescale 1ns / 1ps
module block_and_window_vector_average_test;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [9:0]         i_row;
    logic signed [31:0] i_sample;
    logic               o_valid;
    logic               i_ready;
    logic [9:0]         o_out_row;
    logic signed [31:0] o_average;
    logic [31:0]        o_normalizer;
    logic               o_last_row;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    int                 err_count;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    block_and_window_vector_average i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_row(i_row), .i_sample(i_sample),
        .o_valid(o_valid), .i_ready(i_ready), .o_out_row(o_out_row),
        .o_average(o_average), .o_normalizer(o_normalizer), .o_last_row(o_last_row),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    bwva_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_row(i_row), .i_sample(i_sample),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_row(o_out_row),
        .i_average(o_average), .i_normalizer(o_normalizer), .i_last_row(o_last_row),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(err_count), .o_pending(pending)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver stalls at random.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(131072)) - 32'd65536;
            default: return $urandom;
        endcase
    endfunction

    // Send one item, with an optional idle gap before it.
    task automatic send_item(logic [9:0] row, logic [31:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_row <= row;
        i_sample <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Write all four registers back to back, then release the port.
    task automatic set_regs(int mode, int reps, int win, int rows);
        logic [31:0] vals [4];
        vals[0] = mode;
        vals[1] = reps;
        vals[2] = win;
        vals[3] = rows;
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 2'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain all results and let the block settle before the next setting.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // Whole vectors in row order; broken ones drop rows and carry ignored rows.
    task automatic run_vectors(int nvec, int rows, bit broken);
        for (int v = 0; v < nvec; v++) begin
            for (int r = 0; r < rows; r++) begin
                if (broken && r < rows - 1 && $urandom_range(9) == 0) continue;
                if (broken && rows < 1024 && $urandom_range(14) == 0)
                    send_item(10'($urandom_range(1023, rows)), pick_sample());
                send_item(10'(r), pick_sample());
            end
        end
    endtask

    // Rows in any order, for settings where every item is a final repeat.
    task automatic run_scatter(int n);
        for (int k = 0; k < n; k++) send_item(10'($urandom_range(1023)), pick_sample());
    endtask

    task automatic set_idle(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
        endcase
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_row = '0;
        i_sample = '0;
        i_ready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = bwva_pkg::REG_MODE;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings and field extremes.
        send_item(10'd0, 32'h7FFF_FFFF);
        send_item(10'd1023, 32'h8000_0000);
        send_item(10'd512, 32'hFFFF_FFFF);
        send_item(10'd1023, 32'h0000_0000);
        send_item(10'h2AA, 32'h5555_5555);
        send_item(10'h155, 32'hAAAA_AAAA);
        drain();
        // Spare mode code with zero registers, which act as one.
        set_regs(bwva_pkg::MODE_RESERVED, 0, 0, 0);
        send_item(10'd0, 32'h8000_0000);
        send_item(10'd1, 32'd5);
        send_item(10'd0, 32'h7FFF_FFFF);
        drain();
        // Running sum with an oversized row count.
        set_regs(bwva_pkg::MODE_RUNNING, 1, 1, 2047);
        send_item(10'd1023, 32'h7FFF_FFFF);
        send_item(10'd1023, 32'h7FFF_FFFF);
        send_item(10'd0, 32'h8000_0000);
        send_item(10'd1023, 32'h8000_0000);
        drain();

        // Fill every window slot of the first eight rows.
        set_regs(bwva_pkg::MODE_WINDOW, 1, 16, 8);
        run_vectors(16, 8, 1'b0);
        drain();

        for (int p = 0; p < 12; p++) begin
            set_idle(p);
            case (p)
                0: begin set_regs(bwva_pkg::MODE_WINDOW, 1, 16, 8); run_vectors(6, 8, 1); end
                1: begin set_regs(bwva_pkg::MODE_WINDOW, 3, 5, 8); run_vectors(9, 8, 1); end
                2: begin set_regs(bwva_pkg::MODE_WINDOW, 2, 31, 4); run_vectors(12, 4, 1); end
                3: begin set_regs(bwva_pkg::MODE_WINDOW, 1, 0, 3); run_vectors(10, 3, 1); end
                4: begin set_regs(bwva_pkg::MODE_RUNNING, 4, 7, 8); run_vectors(8, 8, 1); end
                5: begin set_regs(bwva_pkg::MODE_LATEST, 1, 1, 1024); run_scatter(20); end
                6: begin set_regs(bwva_pkg::MODE_RESERVED, 1, 9, 600); run_scatter(20); end
                7: begin set_regs(bwva_pkg::MODE_RUNNING, 1, 2, 1024); run_scatter(20); end
                8: begin set_regs(bwva_pkg::MODE_LATEST, 300, 1, 1); run_vectors(256, 1, 0); end
                9: begin set_regs(bwva_pkg::MODE_WINDOW, 1, 1, 8); run_vectors(5, 8, 1); end
                10: begin set_regs(bwva_pkg::MODE_WINDOW, 2, 12, 6); run_vectors(8, 6, 1); end
                default: begin
                    set_regs(bwva_pkg::MODE_RUNNING, 5, 3, 2);
                    run_vectors(20, 2, 1);
                end
            endcase
            drain();
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
